>>> rtl/core/hevc_access_unit_splitter_top_assert.svh
// Assertion macros shared by the splitter's front and queue modules.
// Each expects a clock named clk and a reset named rst in scope.
`ifndef HEVC_ACCESS_UNIT_SPLITTER_TOP_ASSERT_SVH
`define HEVC_ACCESS_UNIT_SPLITTER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define HAUS_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HAUS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HAUS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/haus_pkg.sv
`timescale 1ns / 1ps

package haus_pkg;

  localparam int OFFSET_BITS   = 26;
  localparam int MAX_UNITS     = 1048576;
  localparam int WIN_LEN       = 6;
  localparam int UNIT_OFFSET_W = 26;
  localparam int UNIT_INDEX_W  = 20;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [UNIT_INDEX_W-1:0] UNIT_LIMIT = UNIT_INDEX_W'(MAX_UNITS - 1);
  localparam logic [OFFSET_BITS-1:0]  OFFSET_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [7:0] WIN_RESET_BYTE  = 8'hFF;
  localparam logic [7:0] SC_ZERO         = 8'h00;
  localparam logic [7:0] SC_ONE          = 8'h01;
  localparam logic [7:0] NAL_TYPE_MASK   = 8'h7E;
  localparam logic [7:0] FIRST_SLICE_BIT = 8'h80;
  localparam logic [5:0] NAL_SLICE_MAX   = 6'd21;
  localparam logic [5:0] NAL_PARAM_MIN   = 6'd32;
  localparam logic [5:0] NAL_PARAM_MAX   = 6'd34;

  typedef struct packed {
    logic [UNIT_OFFSET_W-1:0] unit_offset;
    logic                     starts_with_params;
    logic [UNIT_INDEX_W-1:0]  unit_index;
  } unit_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_st_t;

endpackage

>>> rtl/core/haus_front.sv
`timescale 1ns / 1ps

module haus_front
  import haus_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       in_ready,
  input  queue_st_t  q_st,
  output logic       push,
  output unit_t      push_data
);

  logic [7:0]              win [WIN_LEN];
  logic [OFFSET_BITS-1:0]  byte_offset;
  logic                    param_run_open;
  logic [UNIT_INDEX_W-1:0] unit_count;

  logic                   accept;
  logic [5:0]             nal_kind;
  logic                   first_slice;
  logic                   start_hit;
  logic                   is_slice;
  logic                   is_param;
  logic                   emit;
  logic [OFFSET_BITS-1:0] off;

  assign in_ready = !q_st.full;
  assign accept   = in_valid && in_ready;

  assign nal_kind    = 6'((win[3] & NAL_TYPE_MASK) >> 1);
  assign first_slice = (win[5] & FIRST_SLICE_BIT) != 8'h00;
  assign start_hit   = (win[0] == SC_ZERO) && (win[1] == SC_ZERO) && (win[2] == SC_ONE)
                       && (unit_count < UNIT_LIMIT);
  assign is_slice    = (nal_kind <= NAL_SLICE_MAX) && first_slice;
  assign is_param    = (nal_kind >= NAL_PARAM_MIN) && (nal_kind <= NAL_PARAM_MAX);
  assign emit        = start_hit && !param_run_open && (is_slice || is_param);

  always_comb begin
    if (byte_offset == OFFSET_MAX) begin
      off = OFFSET_MAX;
    end else if (byte_offset >= OFFSET_BITS'(WIN_LEN)) begin
      off = byte_offset - OFFSET_BITS'(WIN_LEN);
    end else begin
      off = '0;
    end
  end

  assign push                         = accept && emit;
  assign push_data.unit_offset        = UNIT_OFFSET_W'(off);
  assign push_data.starts_with_params = is_param;
  assign push_data.unit_index         = unit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] <= WIN_RESET_BYTE;
      end
      byte_offset    <= '0;
      param_run_open <= 1'b0;
      unit_count     <= '0;
    end else if (accept) begin
      if (start_hit) begin
        if (is_slice) begin
          param_run_open <= 1'b0;
        end else if (is_param) begin
          param_run_open <= 1'b1;
        end
      end
      if (in_last) begin
        for (int i = 0; i < WIN_LEN; i++) begin
          win[i] <= WIN_RESET_BYTE;
        end
        byte_offset <= '0;
        unit_count  <= '0;
      end else begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WIN_LEN-1] <= in_data;
        if (byte_offset != OFFSET_MAX) begin
          byte_offset <= byte_offset + 1'b1;
        end
        if (emit) begin
          unit_count <= unit_count + 1'b1;
        end
      end
    end
  end

`include "hevc_access_unit_splitter_top_assert.svh"

  `HAUS_ASSERT_NEXT(a_eos_clears, accept && in_last, byte_offset == '0 && unit_count == '0, "stream state not cleared after last item")
  `HAUS_ASSERT_IMP(a_push_below_limit, push, unit_count < UNIT_LIMIT, "unit pushed beyond limit")
  `HAUS_ASSERT_NEXT(a_param_opens_run, push && push_data.starts_with_params, param_run_open, "parameter-led unit left run closed")

endmodule

>>> rtl/core/haus_queue.sv
`timescale 1ns / 1ps

module haus_queue
  import haus_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  unit_t     push_data,
  input  logic      pop,
  output unit_t     head,
  output queue_st_t q_st
);

  unit_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_st.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_st.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "hevc_access_unit_splitter_top_assert.svh"

  `HAUS_ASSERT_HOLDS(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
  `HAUS_ASSERT_IMP(a_no_push_full, push, !q_st.full, "push into full queue")
  `HAUS_ASSERT_IMP(a_no_pop_empty, pop, !q_st.empty, "pop from empty queue")

endmodule

>>> rtl/core/haus_back.sv
`timescale 1ns / 1ps

module haus_back
  import haus_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  unit_t     head,
  input  queue_st_t q_st,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output unit_t     out_data
);

  assign pop = !q_st.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

endmodule

>>> rtl/core/hevc_access_unit_splitter_top.sv
`timescale 1ns / 1ps
// Channel   Group   tdata (low bit up)                 tuser / tlast
// input     s_axis  [7:0] data_byte                    tlast: end_of_stream
// output    m_axis  [25:0] unit_offset,                tuser: starts_with_params
//                   [45:26] unit_index, [47:46] zero
//
// One byte is accepted every cycle while the result queue is not full; the judgement
// of a start code is one compare over the six-byte window register in the front stage.
// A unit start reaches m_axis through the result queue, then the output register.
// Reset is synchronous and active high; no clearing pass.
// s_axis_tready drops only while the four-entry result queue is full.

module hevc_access_unit_splitter_top
  import haus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [25:0] unit_offset, [45:26] unit_index
  output logic        m_axis_tuser    // [0] starts_with_params
);

  logic      push;
  unit_t     push_data;
  logic      pop;
  unit_t     head;
  queue_st_t q_st;
  unit_t     out_data;

  haus_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .q_st      (q_st),
    .push      (push),
    .push_data (push_data)
  );

  haus_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_st      (q_st)
  );

  haus_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_st      (q_st),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {2'b00, out_data.unit_index, out_data.unit_offset};
  assign m_axis_tuser = out_data.starts_with_params;

endmodule

>>> test/hevc_au_unit_checker.sv
`timescale 1ns / 1ps

module hevc_au_unit_checker
  import haus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [25:0] unit_offset, [45:26] unit_index, [47:46] zero
  input  logic        m_axis_tuser,   // [0] starts_with_params
  output int          fail_count,
  output int          pending,
  output int          bytes_taken,
  output int          streams_ended,
  output int          units_checked,
  output int          param_units
);

  logic [7:0]              win [WIN_LEN];
  logic [OFFSET_BITS-1:0]  next_offset;
  logic                    run_open;
  logic [UNIT_INDEX_W-1:0] stream_units;
  unit_t                   unit_q [$];

  task automatic clear_stream();
    foreach (win[i]) win[i] = WIN_RESET_BYTE;
    next_offset  = '0;
    stream_units = '0;
  endtask

  task automatic predict_unit(input logic [7:0] cur, input logic eos);
    logic [5:0] nal;
    logic       emit;
    logic       params;
    unit_t      u;
    emit   = 1'b0;
    params = 1'b0;
    if (win[0] == SC_ZERO && win[1] == SC_ZERO && win[2] == SC_ONE &&
        stream_units < UNIT_LIMIT) begin
      nal = 6'((win[3] & NAL_TYPE_MASK) >> 1);
      if (nal <= NAL_SLICE_MAX && (win[5] & FIRST_SLICE_BIT) != 8'h00) begin
        if (run_open) begin
          run_open = 1'b0;
        end else begin
          emit = 1'b1;
        end
      end else if (nal >= NAL_PARAM_MIN && nal <= NAL_PARAM_MAX && !run_open) begin
        run_open = 1'b1;
        emit     = 1'b1;
        params   = 1'b1;
      end
      if (emit) begin
        if (next_offset == OFFSET_MAX) begin
          u.unit_offset = UNIT_OFFSET_W'(OFFSET_MAX);
        end else if (next_offset >= WIN_LEN) begin
          u.unit_offset = UNIT_OFFSET_W'(next_offset - WIN_LEN);
        end else begin
          u.unit_offset = '0;
        end
        u.starts_with_params = params;
        u.unit_index         = stream_units;
        unit_q.push_back(u);
        stream_units++;
      end
    end
    for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
    win[WIN_LEN - 1] = cur;
    if (next_offset != OFFSET_MAX) next_offset++;
    if (eos) clear_stream();
  endtask

  always @(posedge clk) begin : watch
    unit_t got;
    unit_t want;
    if (rst) begin
      clear_stream();
      run_open = 1'b0;
      unit_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.unit_offset        = m_axis_tdata[25:0];
        got.unit_index         = m_axis_tdata[45:26];
        got.starts_with_params = m_axis_tuser;
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected unit, expected none, got offset %0d index %0d params %0b",
                   $time, got.unit_offset, got.unit_index, got.starts_with_params);
          fail_count++;
        end else begin
          want = unit_q.pop_front();
          units_checked++;
          if (want.starts_with_params) param_units++;
          if (got.unit_offset !== want.unit_offset) begin
            $display("%0t: unit_offset expected %0d got %0d",
                     $time, want.unit_offset, got.unit_offset);
            fail_count++;
          end
          if (got.unit_index !== want.unit_index) begin
            $display("%0t: unit_index expected %0d got %0d",
                     $time, want.unit_index, got.unit_index);
            fail_count++;
          end
          if (got.starts_with_params !== want.starts_with_params) begin
            $display("%0t: starts_with_params expected %0b got %0b",
                     $time, want.starts_with_params, got.starts_with_params);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        if (s_axis_tlast) streams_ended++;
        predict_unit(s_axis_tdata, s_axis_tlast);
      end
    end
    pending <= unit_q.size();
  end

endmodule

>>> test/tb_hevc_access_unit_splitter_top.sv
`timescale 1ns / 1ps

module tb_hevc_access_unit_splitter_top;
  import haus_pkg::*;

  localparam logic [5:0] NAL_TRAIL_N    = 6'd0;
  localparam logic [5:0] NAL_IDR_W_RADL = 6'd19;
  localparam logic [5:0] NAL_CRA        = NAL_SLICE_MAX;
  localparam logic [5:0] NAL_RSV_VCL22  = 6'd22;
  localparam logic [5:0] NAL_VPS        = NAL_PARAM_MIN;
  localparam logic [5:0] NAL_SPS        = 6'd33;
  localparam logic [5:0] NAL_PPS        = NAL_PARAM_MAX;
  localparam logic [5:0] NAL_TYPE_TOP   = 6'd63;

  localparam int RANDOM_BYTES = 850;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int pending;
  int bytes_taken;
  int streams_ended;
  int units_checked;
  int param_units;

  stream_byte_t byte_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hevc_access_unit_splitter_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hevc_au_unit_checker unit_watch (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_taken   (bytes_taken),
    .streams_ended (streams_ended),
    .units_checked (units_checked),
    .param_units   (param_units)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] nal_hdr(input logic [5:0] t, input logic fbit,
                                         input logic lbit);
    return {fbit, t, lbit};
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back('{data: b, last: 1'b0});
  endtask

  task automatic push_start();
    push_byte(SC_ZERO);
    push_byte(SC_ZERO);
    push_byte(SC_ONE);
  endtask

  task automatic end_stream();
    stream_byte_t e;
    e = byte_q.pop_back();
    e.last = 1'b1;
    byte_q.push_back(e);
  endtask

  task automatic push_nal(input logic [5:0] t, input logic first, input int plen);
    if ($urandom_range(0, 3) == 0) push_byte(SC_ZERO);
    push_start();
    push_byte(nal_hdr(t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    push_byte(8'($urandom_range(0, 255)));
    push_byte({first, 7'($urandom_range(0, 127))});
    repeat (plen) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_param_sets();
    if ($urandom_range(0, 3) != 0) push_nal(NAL_VPS, 1'($urandom_range(0, 1)), $urandom_range(0, 4));
    push_nal(NAL_SPS, 1'($urandom_range(0, 1)), $urandom_range(0, 4));
    if ($urandom_range(0, 5) == 0) push_nal(NAL_SPS, 1'($urandom_range(0, 1)), 0);
    push_nal(NAL_PPS, 1'($urandom_range(0, 1)), $urandom_range(0, 4));
  endtask

  task automatic push_access_unit();
    int n;
    if ($urandom_range(0, 5) == 0)
      push_nal(6'($urandom_range(NAL_RSV_VCL22, NAL_TYPE_TOP)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 4));
    if ($urandom_range(0, 1) != 0) push_param_sets();
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      push_nal(6'($urandom_range(NAL_TRAIL_N, NAL_SLICE_MAX)), i == 0, $urandom_range(0, 5));
  endtask

  task automatic push_stream();
    repeat ($urandom_range(1, 4)) push_access_unit();
    if ($urandom_range(0, 5) == 0) begin
      push_param_sets();
      push_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) != 0) end_stream();
  endtask

  task automatic push_noise();
    repeat ($urandom_range(4, 24)) begin
      if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 1)));
      else push_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) end_stream();
  endtask

  task automatic push_broken();
    push_start();
    push_byte(nal_hdr(6'($urandom_range(0, NAL_TYPE_TOP)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1))));
    repeat ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 255)));
    end_stream();
  endtask

  initial begin : stimulus
    stream_byte_t item;
    int           gap;
    int           steady;
    int           target;
    int           pick;
    // parameter run opened, kept through a second set, closed by a slice
    push_start(); push_byte(nal_hdr(NAL_VPS, 1'b0, 1'b0));
    push_start(); push_byte(nal_hdr(NAL_SPS, 1'b1, 1'b1));
    push_start(); push_byte(nal_hdr(NAL_IDR_W_RADL, 1'b0, 1'b0));
    push_byte(8'hFF); push_byte(FIRST_SLICE_BIT);
    push_start(); push_byte(nal_hdr(NAL_TRAIL_N, 1'b0, 1'b1));
    push_byte(8'hFF); push_byte(FIRST_SLICE_BIT);
    push_start(); push_byte(nal_hdr(NAL_CRA, 1'b0, 1'b0));
    push_start(); push_byte(nal_hdr(NAL_CRA, 1'b0, 1'b0));
    push_byte(SC_ONE); push_byte(FIRST_SLICE_BIT);
    // start code cut short by end of stream
    push_start(); push_byte(nal_hdr(NAL_PPS, 1'b0, 1'b0)); push_byte(SC_ONE);
    end_stream();

    target = byte_q.size() + RANDOM_BYTES;
    while (byte_q.size() < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) push_stream();
      else if (pick < 18) push_noise();
      else push_broken();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    steady = 0;
    while (byte_q.size() != 0) begin
      item = byte_q.pop_front();
      if (steady > 0) begin
        steady--;
        gap = 0;
      end else begin
        gap = gap_len();
        if ($urandom_range(0, 59) == 0) steady = $urandom_range(30, 80);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= item.data;
      s_axis_tlast  <= item.last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes with %0d stream ends, under random gaps and stalls",
             bytes_taken, streams_ended);
    $display("checked %0d units, %0d of them led by parameter sets",
             units_checked, param_units);
    if (fail_count == 0 && pending == 0) begin
      $display("hevc_access_unit_splitter_top: match");
    end else begin
      $display("hevc_access_unit_splitter_top: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    int cyc;
    int run;
    int next_hold_at;
    int holds_done;
    cyc          = 0;
    next_hold_at = 300;
    holds_done   = 0;
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      cyc += run;
      if (holds_done < 2 && cyc >= next_hold_at) begin
        // hold off long enough for the result queue to fill
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
        holds_done++;
        next_hold_at = cyc + 700;
      end else begin
        run = gap_len();
        if (run > 0) begin
          m_axis_tready <= 1'b0;
          repeat (run) @(posedge clk);
          cyc += run;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("hevc_access_unit_splitter_top: mismatch");
    $finish;
  end

endmodule

>>> hevc_access_unit_splitter_top.f
+incdir+rtl/core
rtl/core/haus_pkg.sv
rtl/core/haus_front.sv
rtl/core/haus_queue.sv
rtl/core/haus_back.sv
rtl/core/hevc_access_unit_splitter_top.sv
test/hevc_au_unit_checker.sv
test/tb_hevc_access_unit_splitter_top.sv
